### rtl/core/mof_pkg.sv
package mof_pkg;

   // Field widths
   localparam int WheelWidth  = 20;
   localparam int ImuWidth    = 24;
   localparam int SpeedWidth  = 32;
   localparam int ScaleWidth  = 32;
   localparam int GainWidth   = 17;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDatWidth = 32;

   // Datapath widths
   localparam int SumWidth    = WheelWidth + 3;
   localparam int OpWidth     = SpeedWidth + 1;
   localparam int ProdWidth   = 56;
   localparam int AccWidth    = 48;
   localparam int StepWidth   = 4;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_LINEAR_SCALE  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ANGULAR_SCALE = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_GYRO_SCALE    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_ACCEL_STEP    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_DRIFT_GAIN    = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_LINEAR_BLEND  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_ANGULAR_BLEND = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_SMOOTHING     = 3'd7;

   // Register reset values
   localparam logic [ScaleWidth-1:0] LINEAR_SCALE_RST  = 32'd22548;
   localparam logic [ScaleWidth-1:0] ANGULAR_SCALE_RST = 32'd3229277;
   localparam logic [ScaleWidth-1:0] GYRO_SCALE_RST    = 32'd961263669;
   localparam logic [ScaleWidth-1:0] ACCEL_STEP_RST    = 32'd4294967;
   localparam logic [GainWidth-1:0]  DRIFT_GAIN_RST    = 17'd1311;
   localparam logic [GainWidth-1:0]  LINEAR_BLEND_RST  = 17'd3277;
   localparam logic [GainWidth-1:0]  ANGULAR_BLEND_RST = 17'd52429;
   localparam logic [GainWidth-1:0]  SMOOTHING_RST     = 17'd19661;
   localparam logic [GainWidth-1:0]  GAIN_ONE          = 17'd65536;

   typedef enum logic [2:0] {
      OPA_SX, OPA_SY, OPA_SW, OPA_GZ, OPA_AX, OPA_AY, OPA_DIFF
   } opa_sel_type;

   typedef enum logic [2:0] {
      COEF_LINEAR, COEF_ANGULAR, COEF_GYRO, COEF_STEP,
      COEF_DRIFT, COEF_LBLEND, COEF_ABLEND, COEF_SMOOTH
   } coef_sel_type;

   typedef enum logic [3:0] {
      REG_ZERO, REG_ENC_X, REG_ENC_Y, REG_ENC_W, REG_GYRO,
      REG_INER_X, REG_INER_Y, REG_SMOOTH_X, REG_SMOOTH_Y, REG_SMOOTH_W
   } reg_sel_type;

   typedef enum logic [1:0] {
      SHIFT_10, SHIFT_16, SHIFT_24, SHIFT_32
   } shift_sel_type;

   typedef enum logic {
      SEQ_NEXT, SEQ_END
   } seq_op_type;

   typedef enum logic {
      ST_IDLE, ST_RUN
   } fsm_state_type;

   // One control word: multiply fields for this step, write-back fields
   // for the product registered in the step before
   typedef struct packed {
      logic          mul_en;
      opa_sel_type   opa;
      reg_sel_type   minuend;
      reg_sel_type   subtrahend;
      coef_sel_type  coef;
      logic          wb_en;
      shift_sel_type shift;
      reg_sel_type   base;
      reg_sel_type   dest;
      seq_op_type    seq;
   } ctl_word_type;

   function automatic ctl_word_type uop(
      input logic          mul_en,
      input opa_sel_type   opa,
      input reg_sel_type   minuend,
      input reg_sel_type   subtrahend,
      input coef_sel_type  coef,
      input logic          wb_en,
      input shift_sel_type shift,
      input reg_sel_type   base,
      input reg_sel_type   dest,
      input seq_op_type    seq
   );
      ctl_word_type w;
      w.mul_en     = mul_en;
      w.opa        = opa;
      w.minuend    = minuend;
      w.subtrahend = subtrahend;
      w.coef       = coef;
      w.wb_en      = wb_en;
      w.shift      = shift;
      w.base       = base;
      w.dest       = dest;
      w.seq        = seq;
      return w;
   endfunction

   // Program store: encoder speeds, gyro, integrators, blends, low-pass
   function automatic ctl_word_type microcode(input logic [StepWidth-1:0] step);
      ctl_word_type w;
      unique case (step)
         4'd0:  w = uop(1'b1, OPA_SX, REG_ZERO, REG_ZERO, COEF_LINEAR,
                        1'b0, SHIFT_10, REG_ZERO, REG_ZERO, SEQ_NEXT);
         4'd1:  w = uop(1'b1, OPA_SY, REG_ZERO, REG_ZERO, COEF_LINEAR,
                        1'b1, SHIFT_10, REG_ZERO, REG_ENC_X, SEQ_NEXT);
         4'd2:  w = uop(1'b1, OPA_SW, REG_ZERO, REG_ZERO, COEF_ANGULAR,
                        1'b1, SHIFT_10, REG_ZERO, REG_ENC_Y, SEQ_NEXT);
         4'd3:  w = uop(1'b1, OPA_GZ, REG_ZERO, REG_ZERO, COEF_GYRO,
                        1'b1, SHIFT_10, REG_ZERO, REG_ENC_W, SEQ_NEXT);
         4'd4:  w = uop(1'b1, OPA_AX, REG_ZERO, REG_ZERO, COEF_STEP,
                        1'b1, SHIFT_24, REG_ZERO, REG_GYRO, SEQ_NEXT);
         4'd5:  w = uop(1'b1, OPA_AY, REG_ZERO, REG_ZERO, COEF_STEP,
                        1'b1, SHIFT_32, REG_INER_X, REG_INER_X, SEQ_NEXT);
         4'd6:  w = uop(1'b1, OPA_DIFF, REG_ENC_X, REG_INER_X, COEF_DRIFT,
                        1'b1, SHIFT_32, REG_INER_Y, REG_INER_Y, SEQ_NEXT);
         4'd7:  w = uop(1'b1, OPA_DIFF, REG_ENC_Y, REG_INER_Y, COEF_DRIFT,
                        1'b1, SHIFT_16, REG_INER_X, REG_INER_X, SEQ_NEXT);
         4'd8:  w = uop(1'b1, OPA_DIFF, REG_INER_X, REG_ENC_X, COEF_LBLEND,
                        1'b1, SHIFT_16, REG_INER_Y, REG_INER_Y, SEQ_NEXT);
         4'd9:  w = uop(1'b1, OPA_DIFF, REG_INER_Y, REG_ENC_Y, COEF_LBLEND,
                        1'b1, SHIFT_16, REG_ENC_X, REG_ENC_X, SEQ_NEXT);
         4'd10: w = uop(1'b1, OPA_DIFF, REG_GYRO, REG_ENC_W, COEF_ABLEND,
                        1'b1, SHIFT_16, REG_ENC_Y, REG_ENC_Y, SEQ_NEXT);
         4'd11: w = uop(1'b1, OPA_DIFF, REG_ENC_X, REG_SMOOTH_X, COEF_SMOOTH,
                        1'b1, SHIFT_16, REG_ENC_W, REG_ENC_W, SEQ_NEXT);
         4'd12: w = uop(1'b1, OPA_DIFF, REG_ENC_Y, REG_SMOOTH_Y, COEF_SMOOTH,
                        1'b1, SHIFT_16, REG_SMOOTH_X, REG_SMOOTH_X, SEQ_NEXT);
         4'd13: w = uop(1'b1, OPA_DIFF, REG_ENC_W, REG_SMOOTH_W, COEF_SMOOTH,
                        1'b1, SHIFT_16, REG_SMOOTH_Y, REG_SMOOTH_Y, SEQ_NEXT);
         4'd14: w = uop(1'b0, OPA_DIFF, REG_ZERO, REG_ZERO, COEF_SMOOTH,
                        1'b1, SHIFT_16, REG_SMOOTH_W, REG_SMOOTH_W, SEQ_NEXT);
         4'd15: w = uop(1'b0, OPA_DIFF, REG_ZERO, REG_ZERO, COEF_SMOOTH,
                        1'b0, SHIFT_16, REG_ZERO, REG_ZERO, SEQ_END);
      endcase
      return w;
   endfunction

   // Limit a Q1.16 gain to one
   function automatic logic [GainWidth-1:0] gain_clamp(input logic [GainWidth-1:0] g);
      return (g > GAIN_ONE) ? GAIN_ONE : g;
   endfunction

endpackage

### rtl/core/mecanum_odometry_fusion.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  four wheel speeds, gyro_z, accel_x, accel_y
// rsp_      out        rsp_valid / rsp_stall  speed_forward, speed_lateral, speed_rotation
// csr_      in         csr_write              csr_index, csr_data
//
// A result is valid once its transaction has run through sixteen program
// steps, fourteen of which go through the single shared 33x33 multiplier followed
// by a round, add and saturate stage. No transaction is taken while one runs.
// Reset (synchronous) restores the register defaults and clears the filter state.
// A stalled result holds the sequencer on its final step; a new transaction is
// taken in the cycle after the result has been loaded into the output register.
module mecanum_odometry_fusion (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mof_pkg::WheelWidth-1:0]  req_wheel_left_front,
   input  logic signed [mof_pkg::WheelWidth-1:0]  req_wheel_right_front,
   input  logic signed [mof_pkg::WheelWidth-1:0]  req_wheel_left_back,
   input  logic signed [mof_pkg::WheelWidth-1:0]  req_wheel_right_back,
   input  logic signed [mof_pkg::ImuWidth-1:0]    req_gyro_z,
   input  logic signed [mof_pkg::ImuWidth-1:0]    req_accel_x,
   input  logic signed [mof_pkg::ImuWidth-1:0]    req_accel_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mof_pkg::SpeedWidth-1:0]  rsp_speed_forward,
   output logic signed [mof_pkg::SpeedWidth-1:0]  rsp_speed_lateral,
   output logic signed [mof_pkg::SpeedWidth-1:0]  rsp_speed_rotation,
   input  logic                                   csr_write,
   input  logic [mof_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [mof_pkg::CsrDatWidth-1:0]        csr_data
);
   import mof_pkg::*;

   localparam logic signed [AccWidth-1:0] SatMax = AccWidth'(64'sd2147483647);
   localparam logic signed [AccWidth-1:0] SatMin = -AccWidth'(64'sd2147483648);

   // Configuration registers
   logic [ScaleWidth-1:0] linear_scale_ff, angular_scale_ff, gyro_scale_ff, accel_step_ff;
   logic [GainWidth-1:0]  drift_gain_ff, linear_blend_ff, angular_blend_ff, smoothing_ff;

   // Sequencer
   fsm_state_type         state_ff, state_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   ctl_word_type          ctl;
   logic                  accept, exec, slot_free, rsp_load;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Captured transaction
   logic signed [SumWidth-1:0] sx_ff, sy_ff, sw_ff, sx_in, sy_in, sw_in;
   logic signed [ImuWidth-1:0] gz_ff, ax_ff, ay_ff;
   logic signed [SumWidth-1:0] lf, rf, lb, rb;

   // Working and state registers
   logic signed [SpeedWidth-1:0] enc_x_ff, enc_y_ff, enc_w_ff, gyro_ff;
   logic signed [SpeedWidth-1:0] enc_x_in, enc_y_in, enc_w_in, gyro_in;
   logic signed [SpeedWidth-1:0] iner_x_ff, iner_y_ff, iner_x_in, iner_y_in;
   logic signed [SpeedWidth-1:0] smooth_x_ff, smooth_y_ff, smooth_w_ff;
   logic signed [SpeedWidth-1:0] smooth_x_in, smooth_y_in, smooth_w_in;
   logic signed [SpeedWidth-1:0] rsp_x_ff, rsp_y_ff, rsp_w_ff;

   // Datapath
   logic signed [SpeedWidth-1:0] minuend_val, subtrahend_val, base_val;
   logic signed [OpWidth-1:0]    opa_val, coef_val;
   logic signed [2*OpWidth-1:0]  prod;
   logic signed [ProdWidth-1:0]  prod_ff, prod_in, bias, rounded, shifted;
   logic signed [AccWidth-1:0]   acc;
   logic signed [SpeedWidth-1:0] wb_val;

   function automatic logic signed [SpeedWidth-1:0] reg_read(input reg_sel_type sel);
      logic signed [SpeedWidth-1:0] v;
      unique case (sel)
         REG_ENC_X:    v = enc_x_ff;
         REG_ENC_Y:    v = enc_y_ff;
         REG_ENC_W:    v = enc_w_ff;
         REG_GYRO:     v = gyro_ff;
         REG_INER_X:   v = iner_x_ff;
         REG_INER_Y:   v = iner_y_ff;
         REG_SMOOTH_X: v = smooth_x_ff;
         REG_SMOOTH_Y: v = smooth_y_ff;
         REG_SMOOTH_W: v = smooth_w_ff;
         default:      v = '0;
      endcase
      return v;
   endfunction

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         linear_scale_ff  <= LINEAR_SCALE_RST;
         angular_scale_ff <= ANGULAR_SCALE_RST;
         gyro_scale_ff    <= GYRO_SCALE_RST;
         accel_step_ff    <= ACCEL_STEP_RST;
         drift_gain_ff    <= DRIFT_GAIN_RST;
         linear_blend_ff  <= LINEAR_BLEND_RST;
         angular_blend_ff <= ANGULAR_BLEND_RST;
         smoothing_ff     <= SMOOTHING_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LINEAR_SCALE:  linear_scale_ff  <= csr_data;
            CSR_ANGULAR_SCALE: angular_scale_ff <= csr_data;
            CSR_GYRO_SCALE:    gyro_scale_ff    <= csr_data;
            CSR_ACCEL_STEP:    accel_step_ff    <= csr_data;
            CSR_DRIFT_GAIN:    drift_gain_ff    <= csr_data[GainWidth-1:0];
            CSR_LINEAR_BLEND:  linear_blend_ff  <= csr_data[GainWidth-1:0];
            CSR_ANGULAR_BLEND: angular_blend_ff <= csr_data[GainWidth-1:0];
            CSR_SMOOTHING:     smoothing_ff     <= csr_data[GainWidth-1:0];
         endcase
      end
   end

   // Fetch the control word of the current step
   assign ctl       = microcode(step_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (ctl.seq == SEQ_END && slot_free) state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      exec      = (state_ff == ST_RUN);
      accept    = req_valid && (state_ff == ST_IDLE);
      rsp_load  = exec && (ctl.seq == SEQ_END) && slot_free;
   end

   // Advance the step; hold on the final step while the output is blocked
   always_comb begin
      step_in = step_ff;
      if (!exec) begin
         step_in = '0;
      end else if (ctl.seq == SEQ_END) begin
         if (slot_free) step_in = '0;
      end else begin
         step_in = step_ff + StepWidth'(1);
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Form wheel sums, right-side wheels negated
   always_comb begin
      lf    = SumWidth'(req_wheel_left_front);
      rf    = -SumWidth'(req_wheel_right_front);
      lb    = SumWidth'(req_wheel_left_back);
      rb    = -SumWidth'(req_wheel_right_back);
      sx_in = lf + rf + lb + rb;
      sy_in = -lf + rf + lb - rb;
      sw_in = -lf + rf - lb + rb;
   end

   // Capture the transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sw_ff <= sw_in;
         gz_ff <= req_gyro_z;
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
      end
   end

   // Select multiplier operands
   always_comb begin
      minuend_val    = reg_read(ctl.minuend);
      subtrahend_val = reg_read(ctl.subtrahend);
      unique case (ctl.opa)
         OPA_SX:   opa_val = OpWidth'(sx_ff);
         OPA_SY:   opa_val = OpWidth'(sy_ff);
         OPA_SW:   opa_val = OpWidth'(sw_ff);
         OPA_GZ:   opa_val = OpWidth'(gz_ff);
         OPA_AX:   opa_val = OpWidth'(ax_ff);
         OPA_AY:   opa_val = OpWidth'(ay_ff);
         OPA_DIFF: opa_val = OpWidth'(minuend_val) - OpWidth'(subtrahend_val);
         default:  opa_val = '0;
      endcase
      unique case (ctl.coef)
         COEF_LINEAR:  coef_val = {1'b0, linear_scale_ff};
         COEF_ANGULAR: coef_val = {1'b0, angular_scale_ff};
         COEF_GYRO:    coef_val = {1'b0, gyro_scale_ff};
         COEF_STEP:    coef_val = {1'b0, accel_step_ff};
         COEF_DRIFT:   coef_val = OpWidth'(gain_clamp(drift_gain_ff));
         COEF_LBLEND:  coef_val = OpWidth'(gain_clamp(linear_blend_ff));
         COEF_ABLEND:  coef_val = OpWidth'(gain_clamp(angular_blend_ff));
         COEF_SMOOTH:  coef_val = OpWidth'(gain_clamp(smoothing_ff));
      endcase
      prod    = opa_val * coef_val;
      prod_in = $signed(prod[ProdWidth-1:0]);
   end

   // Register the product
   always_ff @(posedge clock) begin
      if (exec && ctl.mul_en) prod_ff <= prod_in;
   end

   // Round half up, add base, saturate
   always_comb begin
      unique case (ctl.shift)
         SHIFT_10: bias = ProdWidth'(1) <<< 9;
         SHIFT_16: bias = ProdWidth'(1) <<< 15;
         SHIFT_24: bias = ProdWidth'(1) <<< 23;
         SHIFT_32: bias = ProdWidth'(1) <<< 31;
      endcase
      rounded = prod_ff + bias;
      unique case (ctl.shift)
         SHIFT_10: shifted = rounded >>> 10;
         SHIFT_16: shifted = rounded >>> 16;
         SHIFT_24: shifted = rounded >>> 24;
         SHIFT_32: shifted = rounded >>> 32;
      endcase
      base_val = reg_read(ctl.base);
      acc      = AccWidth'(base_val) + AccWidth'(shifted);
      if (acc > SatMax) begin
         wb_val = SatMax[SpeedWidth-1:0];
      end else if (acc < SatMin) begin
         wb_val = SatMin[SpeedWidth-1:0];
      end else begin
         wb_val = acc[SpeedWidth-1:0];
      end
   end

   // Steer the write-back
   always_comb begin
      enc_x_in    = enc_x_ff;
      enc_y_in    = enc_y_ff;
      enc_w_in    = enc_w_ff;
      gyro_in     = gyro_ff;
      iner_x_in   = iner_x_ff;
      iner_y_in   = iner_y_ff;
      smooth_x_in = smooth_x_ff;
      smooth_y_in = smooth_y_ff;
      smooth_w_in = smooth_w_ff;
      if (exec && ctl.wb_en) begin
         unique case (ctl.dest)
            REG_ENC_X:    enc_x_in    = wb_val;
            REG_ENC_Y:    enc_y_in    = wb_val;
            REG_ENC_W:    enc_w_in    = wb_val;
            REG_GYRO:     gyro_in     = wb_val;
            REG_INER_X:   iner_x_in   = wb_val;
            REG_INER_Y:   iner_y_in   = wb_val;
            REG_SMOOTH_X: smooth_x_in = wb_val;
            REG_SMOOTH_Y: smooth_y_in = wb_val;
            REG_SMOOTH_W: smooth_w_in = wb_val;
            default: ;
         endcase
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      enc_x_ff <= enc_x_in;
      enc_y_ff <= enc_y_in;
      enc_w_ff <= enc_w_in;
      gyro_ff  <= gyro_in;
   end

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         iner_x_ff   <= '0;
         iner_y_ff   <= '0;
         smooth_x_ff <= '0;
         smooth_y_ff <= '0;
         smooth_w_ff <= '0;
      end else begin
         iner_x_ff   <= iner_x_in;
         iner_y_ff   <= iner_y_in;
         smooth_x_ff <= smooth_x_in;
         smooth_y_ff <= smooth_y_in;
         smooth_w_ff <= smooth_w_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff <= smooth_x_ff;
         rsp_y_ff <= smooth_y_ff;
         rsp_w_ff <= smooth_w_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_speed_forward  = rsp_x_ff;
   assign rsp_speed_lateral  = rsp_y_ff;
   assign rsp_speed_rotation = rsp_w_ff;

endmodule

### rtl/core/mof_checker.sv
module mof_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [mof_pkg::SpeedWidth-1:0] rsp_speed_forward,
   input logic signed [mof_pkg::SpeedWidth-1:0] rsp_speed_lateral,
   input logic signed [mof_pkg::SpeedWidth-1:0] rsp_speed_rotation
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_speed_forward) &&
         $stable(rsp_speed_lateral) && $stable(rsp_speed_rotation))
      else $error("stalled result changed");

   // Busy after taking a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   // No result straight after a transaction
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result too early");

   // Come out of reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind mecanum_odometry_fusion mof_checker u_mof_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_speed_forward  (rsp_speed_forward),
   .rsp_speed_lateral  (rsp_speed_lateral),
   .rsp_speed_rotation (rsp_speed_rotation)
);
